// ===== hdl/stable_priority_queue_unit_assert.svh =====
// Assertion macros for the stable priority queue unit.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the stable priority queue unit.
// Used by the cell and the top level; depends on nothing else.
package spq_pkg;

  localparam int unsigned SPQ_DEPTH = 16;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned PRIO_W    = 16;
  localparam int unsigned COUNT_W   = 5;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                       req_type;
    logic signed [VALUE_W-1:0]  value;
    logic signed [PRIO_W-1:0]   priority_req;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  pop_value;
    logic                       pop_valid;
    status_e                    status;
    logic [COUNT_W-1:0]         entry_count;
    logic                       queue_empty;
  } rsp_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic signed [PRIO_W-1:0]   prio;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic    push;
    logic    pop;
    entry_t  new_entry;
  } cell_ctrl_t;

endpackage

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and decides each cycle
// whether to keep it, take the new word, or take a neighbor's entry.
// Depends on spq_pkg.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  logic                prev_stays_i,
  input  spq_pkg::entry_t     prev_entry_i,
  input  spq_pkg::entry_t     next_entry_i,
  output spq_pkg::entry_t     entry_o,
  output logic                stays_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // An entry of equal priority stays ahead of the new one, which keeps ties FIFO.
  assign stays_o = occupied_i && ($signed(entry_q.prio) >= $signed(ctrl_i.new_entry.prio));
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.push && !stays_o) begin
      // The first cell that gives way takes the new word; those below shift down.
      entry_d = prev_stays_i ? ctrl_i.new_entry : prev_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== hdl/stable_priority_queue_unit.sv =====
// Stable priority queue unit: a sorted chain of DEPTH cells, highest priority
// at cell 0. One push or pop word is taken every clock cycle (busy never rises),
// and its result appears in the next cycle, for one cycle, with rsp_valid_o high.
// The receiver cannot stall. Depends on spq_pkg and spq_cell.
module stable_priority_queue_unit #(
  parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output spq_pkg::rsp_t rsp_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             rsp_valid_q;
  rsp_t             rsp_q, rsp_d;
  cell_ctrl_t       ctrl;
  entry_t           entries [DEPTH];
  logic             stays   [DEPTH];
  logic             accept, full, empty, push_ok, pop_ok;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign push_ok = accept && (req_i.req_type == REQ_PUSH) && !full;
  assign pop_ok  = accept && (req_i.req_type == REQ_POP) && !empty;

  always_comb begin
    ctrl.push            = push_ok;
    ctrl.pop             = pop_ok;
    ctrl.new_entry.value = req_i.value;
    ctrl.new_entry.prio  = req_i.priority_req;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_s;
    if (i == 0) begin : g_head
      assign prev_e = entries[0];
      assign prev_s = 1'b1;
    end else begin : g_body
      assign prev_e = entries[i-1];
      assign prev_s = stays[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_e = entries[i];
    end else begin : g_link
      assign next_e = entries[i+1];
    end
    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (count_q > CNT_W'(i)),
      .prev_stays_i (prev_s),
      .prev_entry_i (prev_e),
      .next_entry_i (next_e),
      .entry_o      (entries[i]),
      .stays_o      (stays[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (push_ok) begin
      count_d = count_q + 1'b1;
    end else if (pop_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    rsp_d.pop_value   = pop_ok ? entries[0].value : '0;
    rsp_d.pop_valid   = pop_ok;
    rsp_d.entry_count = COUNT_W'(count_d);
    rsp_d.queue_empty = (count_d == '0);
    rsp_d.status      = ST_OK;
    if (accept && (req_i.req_type == REQ_POP) && empty) begin
      rsp_d.status = ST_POP_EMPTY;
    end else if (accept && (req_i.req_type == REQ_PUSH) && full) begin
      rsp_d.status = ST_PUSH_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`include "stable_priority_queue_unit_assert.svh"

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "count exceeds depth")
  `SPQ_ASSERT_NEXT(a_rsp_follows, accept, rsp_valid_o, "accepted word gave no result")
  `SPQ_ASSERT_NEXT(a_push_grows, push_ok, count_q == $past(count_q) + 1'b1, "push lost")
  `SPQ_ASSERT_NOW(a_pop_ok_status, rsp_valid_o && rsp_o.pop_valid, rsp_o.status == ST_OK,
                  "pop result flagged as error")

endmodule

// ===== tb/sv/stable_priority_queue_unit_tb.sv =====
// Testbench for stable_priority_queue_unit: drives push and pop words and checks every
// result against a sorted-array model of the queue kept inside this file.
// Depends on spq_pkg and the RTL of stable_priority_queue_unit.
module stable_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS = 10;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  req_t  req_i;
  logic  rsp_valid_o;
  rsp_t  rsp_o;

  // Model of the queue contents, highest priority at slot 0.
  logic signed [31:0] held_value [SPQ_DEPTH];
  logic signed [15:0] held_prio  [SPQ_DEPTH];
  int                 held_count;

  rsp_t        pending_rsp[$];
  int unsigned n_accepted;
  int unsigned n_errors;
  int unsigned idle_cycles;

  stable_priority_queue_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic req_t make_word(input logic kind, input logic signed [31:0] val,
                                     input logic signed [15:0] prio);
    req_t w;
    w.req_type     = kind;
    w.value        = val;
    w.priority_req = prio;
    return w;
  endfunction

  // Applies one word to the queue model and returns the result it must produce.
  function automatic rsp_t apply_to_queue(input req_t w);
    rsp_t r;
    int   pos;
    int   i;
    r        = '0;
    r.status = ST_OK;
    if (w.req_type == REQ_PUSH) begin
      if (held_count >= SPQ_DEPTH) begin
        r.status = ST_PUSH_FULL;
      end else begin
        // Equal priorities stay ahead of the new entry, so ties leave in arrival order.
        pos = 0;
        while (pos < held_count && held_prio[pos] >= w.priority_req) pos++;
        for (i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[pos] = w.value;
        held_prio[pos]  = w.priority_req;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_POP_EMPTY;
      end else begin
        r.pop_value = held_value[0];
        r.pop_valid = 1'b1;
        for (i = 1; i < held_count; i++) begin
          held_value[i-1] = held_value[i];
          held_prio[i-1]  = held_prio[i];
        end
        held_count--;
      end
    end
    r.entry_count = COUNT_W'(held_count);
    r.queue_empty = (held_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h", field, exp_v, act_v);
  endtask

  // Records accepted words, checks results and watches for a stalled run.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        pending_rsp.push_back(apply_to_queue(req_i));
        n_accepted++;
      end
      if (rsp_valid_o) begin
        if (pending_rsp.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) $display("result with no word outstanding: %h", rsp_o);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_o.pop_value !== want.pop_value)
            report_mismatch("pop_value", want.pop_value, rsp_o.pop_value);
          if (rsp_o.pop_valid !== want.pop_valid)
            report_mismatch("pop_valid", 32'(want.pop_valid), 32'(rsp_o.pop_valid));
          if (rsp_o.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(rsp_o.status));
          if (rsp_o.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(want.entry_count), 32'(rsp_o.entry_count));
          if (rsp_o.queue_empty !== want.queue_empty)
            report_mismatch("queue_empty", 32'(want.queue_empty), 32'(rsp_o.queue_empty));
        end
      end
      if ((start && !busy) || rsp_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input req_t w, input int idle_pct);
    int unsigned seen;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start = 1'b1;
    req_i = w;
    seen  = n_accepted;
    while (n_accepted == seen) @(negedge clk_i);
  endtask

  task automatic test_pop_when_empty();
    send_word(make_word(REQ_POP, 32'sd0, 16'sd0), 0);
    send_word(make_word(REQ_POP, 32'h7fffffff, 16'sh7fff), 0);
  endtask

  // Fills the queue with extreme values and several runs of equal priority,
  // then pushes into the full queue and takes a few words back out.
  task automatic test_fill_and_overflow();
    logic signed [31:0] vals  [16] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff,
                                       32'h1, 32'h2, 32'h3, 32'h4,
                                       32'h5555aaaa, 32'haaaa5555, 32'h11, 32'h12,
                                       32'h13, 32'h21, 32'h22, 32'h23};
    logic signed [15:0] prios [16] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
                                       16'sd5, 16'sd5, 16'sd5, 16'sh7fff,
                                       16'sh8000, 16'sh8000, 16'sd0, 16'sd0,
                                       16'sd5, 16'shffff, 16'shffff, 16'sh7fff};
    int k;
    for (k = 0; k < 16; k++) send_word(make_word(REQ_PUSH, vals[k], prios[k]), 0);
    send_word(make_word(REQ_PUSH, 32'h0badcafe, 16'sh7fff), 0);
    for (k = 0; k < 5; k++) send_word(make_word(REQ_POP, $urandom(), 16'($urandom())), 20);
  endtask

  // Random words in runs that lean toward pushes or pops, so the queue swings
  // between full and empty; narrow priorities produce many ties.
  task automatic test_random_traffic(input int n_words, input int idle_pct);
    int   push_pct;
    int   k;
    req_t w;
    push_pct = 50;
    for (k = 0; k < n_words; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 75;
        endcase
      end
      w.req_type = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
      w.value    = $urandom();
      case ($urandom_range(3))
        0, 1: w.priority_req = 16'($urandom());
        2: w.priority_req = 16'($urandom_range(3)) - 16'sd1;
        default: w.priority_req = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      endcase
      send_word(w, idle_pct);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    held_count  = 0;
    n_accepted  = 0;
    n_errors    = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_pop_when_empty();
    test_fill_and_overflow();
    test_random_traffic(300, 0);
    test_random_traffic(300, 51);
    test_random_traffic(300, 26);
    test_random_traffic(300, 0);
    start = 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (n_errors == 0 && pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
